// File: rtl/fprc_pkg.sv
package fprc_pkg;

    // framing bytes
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;

    // checksum mask applied to the running sum
    localparam logic [15:0] CHECK_MASK = 16'hAA55;

    // packet layout
    localparam logic [8:0] HEADER_BYTES  = 9'd5;
    localparam logic [8:0] TRAILER_BYTES = 9'd2;
    localparam logic [8:0] FRAME_MAX     = 9'd262;

    // result kinds
    localparam logic [2:0] KIND_CODE  = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_GOOD  = 3'd2;
    localparam logic [2:0] KIND_BAD   = 3'd3;
    localparam logic [2:0] KIND_FRAME = 3'd4;

    // command passed from the classifier to the checksum stage
    typedef enum logic [3:0] {
        OP_NONE,
        OP_STX,
        OP_CODE,
        OP_LEN,
        OP_ETX,
        OP_DATA,
        OP_CKLO,
        OP_CKHI,
        OP_FRAME
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/fprc_byte_if.sv
interface fprc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

// File: rtl/fprc_result_if.sv
interface fprc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

// File: rtl/framed_packet_receiver_checksum.sv
// Packet deframer for an SOH/STX/code/length/ETX byte stream with a 16-bit
// additive checksum. One byte word is accepted per clock, sustained, as long
// as the result side keeps up; each word is classified combinationally by
// the framing counter, queued, and applied to the 16-bit running sum on pop,
// so throughput is one word per cycle; the word waits in the queue and its
// result in the output register. The QUEUE_DEPTH-entry queue lets input
// keep flowing for that many words while the result side stalls. Results
// are the code byte (reported once ETX checks out), each data byte, a good
// or bad checksum verdict, or a framing error carrying the bad byte.
module framed_packet_receiver_checksum
    import fprc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    fprc_byte_if.sink     i_byte,
    fprc_result_if.source o_result
);

    logic      w_push;
    logic      w_pop;
    t_cmd      w_push_cmd;
    t_cmd      w_pop_cmd;
    t_q_status w_q_status;

    // classify incoming words
    fprc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // decouple classifier from checksum stage
    fprc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_pop_cmd),
        .o_status (w_q_status)
    );

    // accumulate, check and report
    fprc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_pop_cmd),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_result   (o_result)
    );

endmodule

// File: rtl/fprc_front.sv
module fprc_front
    import fprc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    fprc_byte_if.sink         i_byte,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [8:0] r_position;
    logic [8:0] n_position;
    logic [8:0] r_frame_total;
    logic [8:0] n_frame_total;
    logic [9:0] w_next_pos;
    logic [9:0] w_next_pos_1;
    logic [9:0] w_total_ext;
    logic       w_fire;
    t_op        w_op;

    // take a word whenever the queue has room
    assign i_byte.ready = !i_q_status.full;
    assign w_fire       = i_byte.valid && i_byte.ready;

    assign w_next_pos   = {1'b0, r_position} + 10'd1;
    assign w_next_pos_1 = w_next_pos + 10'd1;
    assign w_total_ext  = {1'b0, r_frame_total};

    // classify the word by its place in the packet
    always_comb begin
        n_position    = r_position;
        n_frame_total = r_frame_total;
        w_op          = OP_NONE;
        if (r_position == 9'd0) begin
            if (i_byte.byte_in == BYTE_SOH) begin
                n_position    = 9'd1;
                n_frame_total = HEADER_BYTES;
            end
        end else begin
            n_position = w_next_pos[8:0];
            if (w_next_pos == 10'd2) begin
                if (i_byte.byte_in != BYTE_STX) begin
                    n_position = 9'd0;
                    w_op       = OP_FRAME;
                end else begin
                    w_op = OP_STX;
                end
            end else if (w_next_pos == 10'd3) begin
                w_op = OP_CODE;
            end else if (w_next_pos == 10'd4) begin
                w_op          = OP_LEN;
                n_frame_total = HEADER_BYTES + {1'b0, i_byte.byte_in} + TRAILER_BYTES;
            end else if (w_next_pos == 10'd5) begin
                if (i_byte.byte_in != BYTE_ETX) begin
                    n_position = 9'd0;
                    w_op       = OP_FRAME;
                end else begin
                    w_op = OP_ETX;
                end
            end else if (w_next_pos_1 < w_total_ext) begin
                w_op = OP_DATA;
            end else if (w_next_pos_1 == w_total_ext) begin
                w_op = OP_CKLO;
            end else begin
                n_position = 9'd0;
                w_op       = OP_CKHI;
            end
        end
    end

    // hand classified words to the queue; hunting words are dropped
    assign o_push     = w_fire && (w_op != OP_NONE);
    assign o_cmd.op   = w_op;
    assign o_cmd.data = i_byte.byte_in;

    // advance the framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position    <= 9'd0;
            r_frame_total <= 9'd0;
        end else if (w_fire) begin
            r_position    <= n_position;
            r_frame_total <= n_frame_total;
        end
    end

`ifndef SYNTHESIS
    a_position_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= FRAME_MAX)
        else $error("packet position ran past the longest frame");
`endif

endmodule

// File: rtl/fprc_queue.sv
module fprc_queue
    import fprc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    // store the pushed word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into a full queue");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule

// File: rtl/fprc_back.sv
module fprc_back
    import fprc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  t_q_status     i_q_status,
    output logic          o_pop,
    fprc_result_if.source o_result
);

    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [2:0]  n_kind;
    logic [7:0]  r_value;
    logic [7:0]  n_value;
    logic [15:0] r_sum;
    logic [15:0] n_sum;
    logic [7:0]  r_check_low;
    logic [7:0]  r_code_hold;
    logic        w_emit;
    logic [15:0] w_got;

    // pull a word whenever the output register is free or draining
    assign o_pop = !i_q_status.empty && (!r_out_valid || o_result.ready);
    assign w_got = {i_cmd.data, r_check_low};

    // execute the command
    always_comb begin
        n_sum   = r_sum;
        n_kind  = KIND_DATA;
        n_value = i_cmd.data;
        w_emit  = 1'b0;
        case (i_cmd.op)
            OP_STX: begin
                n_sum = {8'd0, i_cmd.data};
            end
            OP_CODE, OP_LEN: begin
                n_sum = r_sum + {8'd0, i_cmd.data};
            end
            OP_ETX: begin
                n_sum   = r_sum + {8'd0, i_cmd.data};
                n_kind  = KIND_CODE;
                n_value = r_code_hold;
                w_emit  = 1'b1;
            end
            OP_DATA: begin
                n_sum  = r_sum + {8'd0, i_cmd.data};
                n_kind = KIND_DATA;
                w_emit = 1'b1;
            end
            OP_CKHI: begin
                n_kind = (w_got == (r_sum ^ CHECK_MASK)) ? KIND_GOOD : KIND_BAD;
                w_emit = 1'b1;
            end
            OP_FRAME: begin
                n_kind = KIND_FRAME;
                w_emit = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // update the running sum and held bytes
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sum <= n_sum;
            if (i_cmd.op == OP_CODE) begin
                r_code_hold <= i_cmd.data;
            end
            if (i_cmd.op == OP_CKLO) begin
                r_check_low <= i_cmd.data;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_kind  <= n_kind;
            r_value <= n_value;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.kind  = r_kind;
    assign o_result.value = r_value;

`ifndef SYNTHESIS
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_kind <= KIND_FRAME))
        else $error("result kind out of range");
`endif

endmodule

// File: tb/tb_framed_packet_receiver_checksum.sv
`timescale 1ns / 100ps

module tb_framed_packet_receiver_checksum;
    import fprc_pkg::*;

    localparam int WORDS_PER_PHASE = 180;
    localparam int HOLD_CYCLES     = 120;
    localparam int LIMIT_NS        = 4_000_000;
    localparam int PLAN_ROWS       = 25;
    localparam int IDLE_PLAN  [4]  = '{0, 81, 0, 15};
    localparam int STALL_PLAN [4]  = '{0, 0, 81, 15};

    // how a stimulus row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_QUIET,
        CHK_REPORT
    } t_row_check;

    typedef struct packed {
        t_row_check check;
        logic [2:0] kind;
        logic [7:0] value;
        logic [7:0] data;
    } t_row;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    fprc_byte_if   in_bus ();
    fprc_result_if res_bus ();

    framed_packet_receiver_checksum DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (in_bus),
        .o_result (res_bus)
    );

    // deframer state kept alongside the block
    logic [8:0]  pkt_pos;
    logic [8:0]  pkt_total;
    logic [15:0] pkt_sum;
    logic [7:0]  ck_low;
    logic [7:0]  held_code;

    t_row    word_backlog [$];
    t_report reports_due [$];
    t_row    word_on_bus;

    int  idle_pct;
    int  stall_pct;
    bit  hold_go;
    bit  holding;
    int  phase_words;
    int  words_fed;
    int  reports_seen;
    int  mismatches;
    int  kind_tally [5];

    // directed words: framing corner cases, then one packet per verdict
    t_row plan [PLAN_ROWS] = '{
        '{CHK_QUIET,  KIND_CODE,  8'h00, 8'h00},   // noise while hunting
        '{CHK_QUIET,  KIND_CODE,  8'h00, BYTE_SOH},
        '{CHK_REPORT, KIND_FRAME, BYTE_SOH, BYTE_SOH}, // SOH in the STX slot
        '{CHK_QUIET,  KIND_CODE,  8'h00, BYTE_STX},   // back to hunting, ignored
        '{CHK_QUIET,  KIND_CODE,  8'h00, BYTE_SOH},
        '{CHK_QUIET,  KIND_CODE,  8'h00, BYTE_STX},
        '{CHK_QUIET,  KIND_CODE,  8'h00, 8'hFF},      // code never reported
        '{CHK_QUIET,  KIND_CODE,  8'h00, 8'h00},
        '{CHK_REPORT, KIND_FRAME, 8'h04, 8'h04},      // wrong ETX
        '{CHK_QUIET,  KIND_CODE,  8'h00, BYTE_SOH},
        '{CHK_QUIET,  KIND_CODE,  8'h00, BYTE_STX},
        '{CHK_QUIET,  KIND_CODE,  8'h00, 8'h00},
        '{CHK_QUIET,  KIND_CODE,  8'h00, 8'h00},      // zero length
        '{CHK_REPORT, KIND_CODE,  8'h00, BYTE_ETX},
        '{CHK_QUIET,  KIND_CODE,  8'h00, 8'h50},
        '{CHK_REPORT, KIND_GOOD,  8'hAA, 8'hAA},
        '{CHK_MODEL,  KIND_CODE,  8'h00, BYTE_SOH},
        '{CHK_MODEL,  KIND_CODE,  8'h00, BYTE_STX},
        '{CHK_MODEL,  KIND_CODE,  8'h00, 8'h7E},
        '{CHK_MODEL,  KIND_CODE,  8'h00, 8'h02},
        '{CHK_MODEL,  KIND_CODE,  8'h00, BYTE_ETX},
        '{CHK_MODEL,  KIND_CODE,  8'h00, 8'hFF},
        '{CHK_MODEL,  KIND_CODE,  8'h00, 8'h80},
        '{CHK_MODEL,  KIND_CODE,  8'h00, 8'h00},
        '{CHK_REPORT, KIND_BAD,   8'h00, 8'h00}       // checksum zero is wrong
    };

    // advance the deframer by one word, return the report it causes
    task automatic deframe_byte(input logic [7:0] b, output bit hit, output t_report rep);
        int nth;
        logic [15:0] got;
        hit = 1'b0;
        rep = '0;
        if (pkt_pos == 9'd0) begin
            if (b == BYTE_SOH) begin
                pkt_pos   = 9'd1;
                pkt_total = HEADER_BYTES;
                pkt_sum   = '0;
            end
        end else begin
            nth = int'(pkt_pos) + 1;
            pkt_pos = 9'(nth);
            if (nth == 2) begin
                if (b != BYTE_STX) begin
                    pkt_pos = '0;
                    hit = 1'b1;
                    rep = '{KIND_FRAME, b};
                end else begin
                    pkt_sum += 16'(b);
                end
            end else if (nth == 3) begin
                held_code = b;
                pkt_sum += 16'(b);
            end else if (nth == 4) begin
                pkt_total = HEADER_BYTES + TRAILER_BYTES + 9'(b);
                pkt_sum += 16'(b);
            end else if (nth == 5) begin
                hit = 1'b1;
                if (b != BYTE_ETX) begin
                    pkt_pos = '0;
                    rep = '{KIND_FRAME, b};
                end else begin
                    pkt_sum += 16'(b);
                    rep = '{KIND_CODE, held_code};
                end
            end else if (nth + 1 < int'(pkt_total)) begin
                pkt_sum += 16'(b);
                hit = 1'b1;
                rep = '{KIND_DATA, b};
            end else if (nth + 1 == int'(pkt_total)) begin
                ck_low = b;
            end else begin
                // high checksum byte closes the packet
                got = {b, ck_low};
                pkt_pos = '0;
                hit = 1'b1;
                rep = '{(got == (pkt_sum ^ CHECK_MASK)) ? KIND_GOOD : KIND_BAD, b};
            end
        end
    endtask

    task automatic push_word(input logic [7:0] b, input bit counts);
        t_row row;
        row = '{CHK_MODEL, KIND_CODE, 8'h00, b};
        word_backlog.push_back(row);
        if (counts) begin
            phase_words++;
        end
    endtask

    // build one packet; cut limits how many of its words go out
    task automatic queue_frame(input int len, input int cut, input bit bad_etx, input bit spoil);
        logic [7:0]  pkt [$];
        logic [15:0] csum;
        logic [7:0]  b;
        int          sent;
        pkt.push_back(BYTE_SOH);
        pkt.push_back(BYTE_STX);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'(len));
        b = BYTE_ETX;
        if (bad_etx) begin
            do b = 8'($urandom); while (b == BYTE_ETX);
        end
        pkt.push_back(b);
        repeat (len) pkt.push_back(8'($urandom));
        csum = '0;
        for (int i = 1; i < pkt.size(); i++) begin
            csum += 16'(pkt[i]);
        end
        csum ^= CHECK_MASK;
        if (spoil) begin
            csum ^= 16'(1) << $urandom_range(0, 15);
        end
        pkt.push_back(csum[7:0]);
        pkt.push_back(csum[15:8]);
        sent = cut;
        if (bad_etx) begin
            sent = 5;
        end
        if (sent < 0 || sent > pkt.size()) begin
            sent = pkt.size();
        end
        for (int i = 0; i < sent; i++) begin
            push_word(pkt[i], 1'b1);
        end
    endtask

    // mostly well-formed packets, the rest noise and broken framing
    task automatic queue_random_packet();
        int shape;
        int len;
        logic [7:0] b;
        shape = $urandom_range(0, 99);
        len = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        if (shape < 8) begin
            repeat ($urandom_range(1, 4)) push_word(8'($urandom), 1'b0);
        end else if (shape < 14) begin
            push_word(BYTE_SOH, 1'b1);
            do b = 8'($urandom); while (b == BYTE_STX);
            if ($urandom_range(0, 3) == 0) begin
                b = BYTE_SOH;
            end
            push_word(b, 1'b1);
        end else if (shape < 20) begin
            queue_frame(len, -1, 1'b1, 1'b0);
        end else if (shape < 26) begin
            queue_frame(len, $urandom_range(3, len + 6), 1'b0, 1'b0);
        end else begin
            queue_frame(len, -1, 1'b0, $urandom_range(0, 4) == 0);
        end
    endtask

    // hold the stimulus until every queued word is taken and every report seen
    task automatic settle();
        while (word_backlog.size() != 0 || in_bus.valid || reports_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_report(input logic [2:0] kind, input logic [7:0] value);
        t_report want;
        reports_seen++;
        if (kind < 3'd5) begin
            kind_tally[kind]++;
        end
        if (reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected result kind %0d value %02h", $realtime, kind, value);
            end
        end else begin
            want = reports_due.pop_front();
            if (kind !== want.kind || value !== want.value) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result %0d expected kind %0d value %02h, got kind %0d value %02h",
                             $realtime, reports_seen, want.kind, want.value, kind, value);
                end
            end
        end
    endtask

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // known levels before the first edge
    initial begin
        in_bus.valid   = 1'b0;
        in_bus.byte_in = '0;
        res_bus.ready  = 1'b0;
    end

    // send side: take the accepted word, then offer the next or idle
    always @(posedge i_clk) begin
        bit      hit;
        t_report rep;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                words_fed++;
                deframe_byte(word_on_bus.data, hit, rep);
                case (word_on_bus.check)
                    CHK_MODEL: begin
                        if (hit) reports_due.push_back(rep);
                    end
                    CHK_REPORT: begin
                        reports_due.push_back('{word_on_bus.kind, word_on_bus.value});
                    end
                    default: ;
                endcase
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (word_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    word_on_bus = word_backlog.pop_front();
                    in_bus.valid   <= 1'b1;
                    in_bus.byte_in <= word_on_bus.data;
                end else begin
                    in_bus.valid   <= 1'b0;
                    in_bus.byte_in <= 8'($urandom);
                end
            end
        end
    end

    // receive side: check each taken result, stall at random or during a hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                check_report(res_bus.kind, res_bus.value);
            end
            res_bus.ready <= !holding && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // one long receiver hold so the block backs up into its input
    initial begin
        holding = 1'b0;
        while (!hold_go) @(posedge i_clk);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        pkt_pos      = '0;
        pkt_total    = '0;
        pkt_sum      = '0;
        ck_low       = '0;
        held_code    = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_go      = 1'b0;
        words_fed    = 0;
        reports_seen = 0;
        mismatches   = 0;
        kind_tally   = '{default: 0};
        word_on_bus  = '0;

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at full rate
        foreach (plan[i]) begin
            word_backlog.push_back(plan[i]);
        end
        settle();

        // random phases, each drained before the next
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct    = IDLE_PLAN[ph];
            stall_pct   = STALL_PLAN[ph];
            phase_words = 0;
            if (ph == 0) begin
                hold_go = 1'b1;
                queue_frame(255, -1, 1'b0, 1'b0);
            end
            while (phase_words < WORDS_PER_PHASE) begin
                queue_random_packet();
            end
            settle();
        end

        repeat (20) @(posedge i_clk);

        $display("fed %0d words through four idle/stall phases and one long result hold",
                 words_fed);
        $display("checked %0d results: %0d code, %0d data, %0d good, %0d bad, %0d framing",
                 reports_seen, kind_tally[0], kind_tally[1], kind_tally[2],
                 kind_tally[3], kind_tally[4]);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     reports_due.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
